>>> rtl/rtt_est_pkg.sv
package rtt_est_pkg;

  typedef enum logic [1:0] {
    KIND_NEW_PACKET = 2'd0,
    KIND_MEASURE    = 2'd1,
    KIND_TIMEOUT    = 2'd2,
    KIND_QUERY      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_MIN_RTO     = 2'd0,
    REG_MAX_RTO     = 2'd1,
    REG_MAX_RETX    = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_e;

  localparam logic [15:0] RESET_MIN_RTO  = 16'd2000;
  localparam logic [15:0] RESET_MAX_RTO  = 16'd60000;
  localparam logic [7:0]  RESET_MAX_RETX = 8'd3;
  localparam logic [15:0] RESET_SRTT     = 16'd0;
  localparam logic [15:0] RESET_DEV      = 16'd750;
  // srtt + 4*dev at reset, already inside the reset bounds
  localparam logic [15:0] RESET_RTO      = 16'd3000;
  localparam logic [7:0]  COUNT_MAX      = 8'hFF;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] measured_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rto_ms;
    logic        give_up;
  } out_item_t;

  typedef struct packed {
    logic [15:0] min_rto_ms;
    logic [15:0] max_rto_ms;
    logic [7:0]  max_retransmits;
  } cfg_t;

  typedef struct packed {
    logic [15:0] srtt;
    logic [15:0] dev;
    logic [15:0] rto;
    logic [7:0]  count;
  } est_state_t;

endpackage

>>> rtl/rtt_estimator_rto.sv
// Round-trip time estimator with retransmission timeout, in milliseconds.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one event per
// transfer: new packet, RTT measurement, timeout or query. Every event gives
// exactly one result on the output channel (out_valid_o/out_ready_i/
// out_data_o): the timeout in force after the event and a give-up flag.
// An event is captured in an input register, the estimator update runs
// combinationally between that register and the result register, and the
// result is presented from the result register until it transfers. One
// event is taken per cycle while the receiver does not stall; the estimator
// state loops through that single update stage.
// When the receiver stalls, the result register holds and the input
// register fills, after which in_ready_o drops until the result is taken.
// Reset empties both registers, loads the clamp bounds 2000 and 60000 ms
// and a limit of 3 retransmits, smoothed RTT 0, deviation 750 and RTO 3000.
// Register writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once and
// should happen while no event is in flight; stored RTO is not re-clamped.
module rtt_estimator_rto (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  rtt_est_pkg::reg_idx_e  cfg_idx_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rtt_est_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rtt_est_pkg::out_item_t out_data_o
);

  rtt_est_pkg::cfg_t       cfg;
  rtt_est_pkg::est_state_t state_q, state_d;
  rtt_est_pkg::in_item_t   stg_q;
  rtt_est_pkg::out_item_t  out_q, result;
  logic                    stg_valid_q, out_valid_q;
  logic                    advance;

  rtt_est_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rtt_est_update u_update (
    .item_i   (stg_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (result)
  );

  // move the staged event into the result register when that register frees
  assign advance    = stg_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stg_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.srtt  <= rtt_est_pkg::RESET_SRTT;
      state_q.dev   <= rtt_est_pkg::RESET_DEV;
      state_q.rto   <= rtt_est_pkg::RESET_RTO;
      state_q.count <= 8'd0;
    end else begin
      if (in_ready_o) begin
        stg_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stg_valid_q |-> in_ready_o)
    else $error("input refused while input register empty");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid_q && !advance |=> stg_valid_q && $stable(stg_q))
    else $error("staged event dropped or altered without transfer");

  a_state_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("estimator state changed without an event");

  a_give_up_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.give_up |-> state_q.count != 8'd0)
    else $error("give-up flagged with retransmit count at zero");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && stg_q.kind == rtt_est_pkg::KIND_TIMEOUT &&
    state_q.count == rtt_est_pkg::COUNT_MAX |=> state_q.count == rtt_est_pkg::COUNT_MAX)
    else $error("retransmit count wrapped");

endmodule

>>> rtl/rtt_est_cfg.sv
module rtt_est_cfg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  rtt_est_pkg::reg_idx_e   cfg_idx_i,
  input  logic [15:0]             cfg_data_i,
  output rtt_est_pkg::cfg_t       cfg_o
);

  rtt_est_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rtt_est_pkg::REG_MIN_RTO:  cfg_d.min_rto_ms      = cfg_data_i;
        rtt_est_pkg::REG_MAX_RTO:  cfg_d.max_rto_ms      = cfg_data_i;
        rtt_est_pkg::REG_MAX_RETX: cfg_d.max_retransmits = cfg_data_i[7:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_rto_ms      <= rtt_est_pkg::RESET_MIN_RTO;
      cfg_q.max_rto_ms      <= rtt_est_pkg::RESET_MAX_RTO;
      cfg_q.max_retransmits <= rtt_est_pkg::RESET_MAX_RETX;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/rtt_est_update.sv
module rtt_est_update (
  input  rtt_est_pkg::in_item_t   item_i,
  input  rtt_est_pkg::est_state_t state_i,
  input  rtt_est_pkg::cfg_t       cfg_i,
  output rtt_est_pkg::est_state_t state_o,
  output rtt_est_pkg::out_item_t  result_o
);

  function automatic logic [15:0] clamp_rto(input logic [18:0] v,
                                            input logic [15:0] lo,
                                            input logic [15:0] hi);
    logic [15:0] r;
    if (v < {3'b000, lo}) begin
      r = lo;
    end else if (v > {3'b000, hi}) begin
      r = hi;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic        srtt_neg, dev_neg;
  logic [15:0] mag, dev_mag;
  logic [15:0] srtt_new, dev_new;
  logic [18:0] rto_sum, rto_dbl;
  logic [7:0]  count_inc;

  // magnitudes shifted before the sign is applied: truncates toward zero
  always_comb begin
    srtt_neg = item_i.measured_ms < state_i.srtt;
    mag      = srtt_neg ? (state_i.srtt - item_i.measured_ms)
                        : (item_i.measured_ms - state_i.srtt);
    srtt_new = srtt_neg ? (state_i.srtt - (mag >> 3))
                        : (state_i.srtt + (mag >> 3));
    dev_neg  = mag < state_i.dev;
    dev_mag  = dev_neg ? (state_i.dev - mag) : (mag - state_i.dev);
    dev_new  = dev_neg ? (state_i.dev - (dev_mag >> 2))
                       : (state_i.dev + (dev_mag >> 2));
    rto_sum  = {3'b000, srtt_new} + {1'b0, dev_new, 2'b00};
    rto_dbl  = {2'b00, state_i.rto, 1'b0};
    count_inc = (state_i.count != rtt_est_pkg::COUNT_MAX) ?
                (state_i.count + 8'd1) : state_i.count;
  end

  always_comb begin
    state_o          = state_i;
    result_o.give_up = 1'b0;
    unique case (item_i.kind)
      rtt_est_pkg::KIND_NEW_PACKET: begin
        state_o.count = 8'd0;
      end
      rtt_est_pkg::KIND_MEASURE: begin
        state_o.srtt = srtt_new;
        state_o.dev  = dev_new;
        state_o.rto  = clamp_rto(rto_sum, cfg_i.min_rto_ms, cfg_i.max_rto_ms);
      end
      rtt_est_pkg::KIND_TIMEOUT: begin
        state_o.rto      = clamp_rto(rto_dbl, cfg_i.min_rto_ms, cfg_i.max_rto_ms);
        state_o.count    = count_inc;
        result_o.give_up = count_inc > cfg_i.max_retransmits;
      end
      rtt_est_pkg::KIND_QUERY: begin
        state_o = state_i;
      end
      default: begin
        state_o = state_i;
      end
    endcase
    result_o.rto_ms = state_o.rto;
  end

endmodule

>>> verif/rtt_est_checker.sv
module rtt_est_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  rtt_est_pkg::reg_idx_e  cfg_idx_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  rtt_est_pkg::in_item_t  in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  rtt_est_pkg::out_item_t out_data_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);

  // Shadow copy of the bounds and the estimator
  logic [15:0] lo_bound;
  logic [15:0] hi_bound;
  logic [7:0]  retx_limit;
  logic [15:0] srtt;
  logic [15:0] rttvar;
  logic [15:0] rto;
  logic [7:0]  retx_count;

  rtt_est_pkg::out_item_t rto_expect_q[$];
  int unsigned mismatches = 0;
  int unsigned in_flight  = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = in_flight;

  // Below the lower bound wins first, so with min above max a value below min ends at min, any other at max
  function automatic logic [15:0] clamp_rto(logic [31:0] v);
    if (v < {16'd0, lo_bound}) return lo_bound;
    if (v > {16'd0, hi_bound}) return hi_bound;
    return v[15:0];
  endfunction

  function automatic rtt_est_pkg::out_item_t apply_event(rtt_est_pkg::in_item_t ev);
    int                     delta;
    int                     mag;
    int                     srtt_new;
    int                     rttvar_new;
    rtt_est_pkg::out_item_t res;
    res.give_up = 1'b0;
    case (ev.kind)
      rtt_est_pkg::KIND_NEW_PACKET: begin
        retx_count = '0;
      end
      rtt_est_pkg::KIND_MEASURE: begin
        // signed division truncates toward zero, as the update needs
        delta      = int'({16'd0, ev.measured_ms}) - int'({16'd0, srtt});
        srtt_new   = int'({16'd0, srtt}) + delta / 8;
        mag        = (delta < 0) ? -delta : delta;
        rttvar_new = int'({16'd0, rttvar}) + (mag - int'({16'd0, rttvar})) / 4;
        srtt       = srtt_new[15:0];
        rttvar     = rttvar_new[15:0];
        rto        = clamp_rto({16'd0, srtt} + {14'd0, rttvar, 2'b00});
      end
      rtt_est_pkg::KIND_TIMEOUT: begin
        rto = clamp_rto({15'd0, rto, 1'b0});
        if (retx_count != rtt_est_pkg::COUNT_MAX) retx_count++;
        res.give_up = (retx_count > retx_limit);
      end
      default: begin
      end
    endcase
    res.rto_ms = rto;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rtt_est_pkg::out_item_t want;
    if (!rst_ni) begin
      lo_bound   = rtt_est_pkg::RESET_MIN_RTO;
      hi_bound   = rtt_est_pkg::RESET_MAX_RTO;
      retx_limit = rtt_est_pkg::RESET_MAX_RETX;
      srtt       = rtt_est_pkg::RESET_SRTT;
      rttvar     = rtt_est_pkg::RESET_DEV;
      rto        = clamp_rto({16'd0, rtt_est_pkg::RESET_SRTT}
                             + {14'd0, rtt_est_pkg::RESET_DEV, 2'b00});
      retx_count = '0;
      rto_expect_q.delete();
      in_flight  = 0;
    end else begin
      // compare the output transfer before queueing this edge's input
      if (out_valid_i && out_ready_i) begin
        if (rto_expect_q.size() == 0) begin
          $error("unexpected result: rto_ms %0d give_up %0d",
                 out_data_i.rto_ms, out_data_i.give_up);
          mismatches++;
        end else begin
          want = rto_expect_q.pop_front();
          if (out_data_i.rto_ms !== want.rto_ms) begin
            $error("rto_ms: expected %0d, got %0d", want.rto_ms, out_data_i.rto_ms);
            mismatches++;
          end
          if (out_data_i.give_up !== want.give_up) begin
            $error("give_up: expected %0d, got %0d", want.give_up, out_data_i.give_up);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) rto_expect_q.push_back(apply_event(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rtt_est_pkg::REG_MIN_RTO:  lo_bound   = cfg_data_i;
          rtt_est_pkg::REG_MAX_RTO:  hi_bound   = cfg_data_i;
          rtt_est_pkg::REG_MAX_RETX: retx_limit = cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
      in_flight = rto_expect_q.size();
    end
  end

endmodule

>>> verif/testbench.sv
module testbench;

  localparam int CLK_PERIOD      = 12;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_PATTERN,
    SINK_TRICKLE
  } sink_mode_e;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  rtt_est_pkg::reg_idx_e  cfg_idx   = rtt_est_pkg::REG_MIN_RTO;
  logic [15:0]            cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  rtt_est_pkg::in_item_t  in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  rtt_est_pkg::out_item_t out_data;

  int unsigned fail_count;
  int unsigned pending;

  bit          squeeze_req  = 1'b0;
  bit          squeeze_done = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  rtt_estimator_rto u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  rtt_est_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offer one event; gaps fall only between bursts
  task automatic push_event(input rtt_est_pkg::kind_e kind, input logic [15:0] ms);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    if (gap_left != 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, measured_ms: ms};
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  // Write all registers back to back, plus one write to the unused index
  task automatic load_bounds(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [7:0] limit);
    cfg_we   <= 1'b1;
    cfg_idx  <= rtt_est_pkg::REG_MIN_RTO;
    cfg_data <= lo;
    @(posedge clk);
    cfg_idx  <= rtt_est_pkg::REG_MAX_RTO;
    cfg_data <= hi;
    @(posedge clk);
    cfg_idx  <= rtt_est_pkg::REG_MAX_RETX;
    cfg_data <= {8'($urandom), limit};
    @(posedge clk);
    cfg_idx  <= rtt_est_pkg::REG_UNUSED;
    cfg_data <= 16'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic rtt_est_pkg::in_item_t random_event(bit storm);
    rtt_est_pkg::in_item_t ev;
    int unsigned           pick;
    pick = $urandom_range(0, 99);
    if (storm) begin
      // no new packets, so the retransmit count runs into saturation
      if (pick < 92) begin
        ev.kind = rtt_est_pkg::KIND_TIMEOUT;
      end else if (pick < 96) begin
        ev.kind = rtt_est_pkg::KIND_QUERY;
      end else begin
        ev.kind = rtt_est_pkg::KIND_MEASURE;
      end
    end else if (pick < 45) begin
      ev.kind = rtt_est_pkg::KIND_MEASURE;
    end else if (pick < 75) begin
      ev.kind = rtt_est_pkg::KIND_TIMEOUT;
    end else if (pick < 90) begin
      ev.kind = rtt_est_pkg::KIND_NEW_PACKET;
    end else begin
      ev.kind = rtt_est_pkg::KIND_QUERY;
    end
    case ($urandom_range(0, 9))
      0:       ev.measured_ms = 16'd0;
      1:       ev.measured_ms = 16'hFFFF;
      2, 3, 4: ev.measured_ms = 16'($urandom_range(0, 1500));
      5, 6:    ev.measured_ms = 16'($urandom_range(1500, 20000));
      default: ev.measured_ms = 16'($urandom);
    endcase
    return ev;
  endfunction

  // Result sink: stalls on its own pattern, one long hold-off on request
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned seg_left;
    int unsigned tick;
    mode     = SINK_OPEN;
    seg_left = 0;
    tick     = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      tick++;
      if (squeeze_req && !squeeze_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end
      if (seg_left == 0) begin
        mode     = sink_mode_e'($urandom_range(0, 3));
        seg_left = $urandom_range(10, 80);
      end
      seg_left--;
      case (mode)
        SINK_OPEN:    out_ready <= 1'b1;
        SINK_COIN:    out_ready <= 1'($urandom_range(0, 1));
        SINK_PATTERN: out_ready <= ((tick % 4) != 3);
        default:      out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin : stimulus
    rtt_est_pkg::in_item_t ev;
    int unsigned           n_items;
    bit                    storm;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset bounds: walk the timeout past the limit and into the upper clamp
    push_event(rtt_est_pkg::KIND_QUERY, 16'hFFFF);
    repeat (5) push_event(rtt_est_pkg::KIND_TIMEOUT, 16'h0000);
    push_event(rtt_est_pkg::KIND_NEW_PACKET, 16'h5A5A);
    push_event(rtt_est_pkg::KIND_MEASURE, 16'hFFFF);
    push_event(rtt_est_pkg::KIND_MEASURE, 16'hFFFF);
    push_event(rtt_est_pkg::KIND_MEASURE, 16'd0);
    push_event(rtt_est_pkg::KIND_MEASURE, 16'd7);
    push_event(rtt_est_pkg::KIND_MEASURE, 16'd1);
    push_event(rtt_est_pkg::KIND_TIMEOUT, 16'hA5A5);
    push_event(rtt_est_pkg::KIND_QUERY, 16'd0);
    drain();

    // min above max; the stored timeout is not re-clamped until it moves
    load_bounds(16'hFFFF, 16'd0, 8'd0);
    push_event(rtt_est_pkg::KIND_QUERY, 16'd0);
    push_event(rtt_est_pkg::KIND_MEASURE, 16'd0);
    push_event(rtt_est_pkg::KIND_MEASURE, 16'hFFFF);
    push_event(rtt_est_pkg::KIND_TIMEOUT, 16'd0);
    push_event(rtt_est_pkg::KIND_NEW_PACKET, 16'd0);
    drain();

    load_bounds(16'd0, 16'hFFFF, 8'd254);
    push_event(rtt_est_pkg::KIND_MEASURE, 16'd0);
    push_event(rtt_est_pkg::KIND_MEASURE, 16'd0);
    push_event(rtt_est_pkg::KIND_TIMEOUT, 16'd0);
    push_event(rtt_est_pkg::KIND_QUERY, 16'hFFFF);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      storm   = 1'b0;
      n_items = 200;
      case (ph)
        0: load_bounds(16'd0, 16'hFFFF, 8'd0);
        1: load_bounds(16'hFFFF, 16'd0, 8'd254);
        2: load_bounds(16'($urandom_range(0, 3000)), 16'($urandom_range(20000, 65535)),
                       8'($urandom_range(0, 10)));
        3: load_bounds(16'd1, 16'd1, 8'd1);
        4: begin
          load_bounds(16'd100, 16'hFFFF, 8'd254);
          push_event(rtt_est_pkg::KIND_NEW_PACKET, 16'd0);
          storm   = 1'b1;
          n_items = 350;
        end
        5: load_bounds(16'($urandom), 16'($urandom), 8'($urandom_range(0, 254)));
        default: load_bounds(rtt_est_pkg::RESET_MIN_RTO, rtt_est_pkg::RESET_MAX_RTO,
                             rtt_est_pkg::RESET_MAX_RETX);
      endcase
      if (ph == 0) squeeze_req <= 1'b1;
      repeat (n_items) begin
        ev = random_event(storm);
        push_event(ev.kind, ev.measured_ms);
      end
      drain();
    end

    for (int w = 0; w < 2000 && pending != 0; w++) @(negedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * 400_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
